// ===== rtl/iff_pkg.sv =====
package iff_pkg;

    // Sizes of the argument, the digit store and the emitted field.
    localparam int VALUE_W     = 64;
    localparam int DIGIT_SLOTS = 24;
    localparam int MAX_FIELD   = 64;
    localparam int PREC_MAX    = 62;
    localparam int DIGIT_BITS  = DIGIT_SLOTS * 4;
    localparam int OCT_DIGITS  = (VALUE_W + 2) / 3;
    localparam int OCT_EXT_W   = OCT_DIGITS * 3;
    localparam int CNT_W       = $clog2(MAX_FIELD + 1);
    localparam int NDIG_W      = $clog2(DIGIT_SLOTS + 1);
    localparam int STEP_W      = $clog2(VALUE_W);

    // Conversion modes.
    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_LHEX = 3'd2;
    localparam logic [2:0] MODE_UHEX = 3'd3;
    localparam logic [2:0] MODE_OCT  = 3'd4;
    localparam logic [2:0] MODE_CHAR = 3'd5;

    // Characters.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef enum logic [1:0] {
        DU_HOLD,
        DU_LOAD,
        DU_DABBLE,
        DU_SHIFT
    } t_du_op;

    typedef enum logic [1:0] {
        LD_DEC,
        LD_HEX,
        LD_OCT
    } t_load_kind;

    typedef struct packed {
        t_du_op     op;
        t_load_kind kind;
        logic       negate;
    } t_du_ctrl;

    function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
        logic [7:0] base_ch;
        if (digit < 4'd10) begin
            digit_char = CH_ZERO + {4'b0000, digit};
        end else begin
            base_ch    = upper ? CH_A_UP : CH_A_LO;
            digit_char = base_ch + {4'b0000, digit} - 8'd10;
        end
    endfunction

endpackage

// ===== rtl/iff_digit_unit.sv =====
module iff_digit_unit (
    input  logic                          i_clk,
    input  iff_pkg::t_du_ctrl             i_ctrl,
    input  logic [iff_pkg::VALUE_W-1:0]   i_value,
    output logic [3:0]                    o_top_digit
);
    import iff_pkg::*;

    logic [DIGIT_BITS-1:0] r_digits;
    logic [DIGIT_BITS-1:0] n_digits;
    logic [VALUE_W-1:0]    r_work;
    logic [VALUE_W-1:0]    n_work;
    logic [DIGIT_BITS-1:0] adjusted;
    logic [OCT_EXT_W-1:0]  oct_ext;
    logic [VALUE_W-1:0]    magnitude;

    assign magnitude = i_ctrl.negate ? (~i_value + VALUE_W'(1)) : i_value;
    assign oct_ext   = OCT_EXT_W'(i_value);

    // Every BCD digit of five or more gets three added before the doubling shift.
    always_comb begin
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            if (r_digits[4*k +: 4] >= 4'd5) begin
                adjusted[4*k +: 4] = r_digits[4*k +: 4] + 4'd3;
            end else begin
                adjusted[4*k +: 4] = r_digits[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_digits = r_digits;
        n_work   = r_work;
        unique case (i_ctrl.op)
            DU_LOAD: begin
                unique case (i_ctrl.kind)
                    LD_HEX: begin
                        n_digits = DIGIT_BITS'(i_value);
                    end
                    LD_OCT: begin
                        n_digits = '0;
                        for (int k = 0; k < OCT_DIGITS; k++) begin
                            n_digits[4*k +: 4] = {1'b0, oct_ext[3*k +: 3]};
                        end
                    end
                    default: begin
                        n_digits = '0;
                        n_work   = magnitude;
                    end
                endcase
            end
            DU_DABBLE: begin
                n_digits = {adjusted[DIGIT_BITS-2:0], r_work[VALUE_W-1]};
                n_work   = {r_work[VALUE_W-2:0], 1'b0};
            end
            DU_SHIFT: begin
                n_digits = {r_digits[DIGIT_BITS-5:0], 4'b0000};
            end
            default: begin
                n_digits = r_digits;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_work   <= n_work;
    end

    assign o_top_digit = r_digits[DIGIT_BITS-1 -: 4];

endmodule

// ===== rtl/integer_field_formatter.sv =====
// Formats one printf-style integer conversion (%d %u %x %X %o %c) and sends
// the text out one character per output word, with o_last on the final word
// and a single o_empty_res word when the field is empty. The block takes one
// request at a time and stalls its input until the last word is registered.
// A request passes through a load step, double-dabble steps over all 64 value
// bits for decimal modes (none for hex, octal and character), up to 23 shifts
// that strip leading zero digits plus a step that ends the strip (none in
// character mode), a planning and a sizing step, a step at each phase boundary
// that the field passes (four at most), and then one character per cycle while
// the output does not stall. The binary to BCD conversion in the shared digit
// unit and the one-character-per-cycle output take most of a decimal request.
module integer_field_formatter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_mode,
    input  logic [iff_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_pad_after,
    input  logic                         i_plus_flag,
    input  logic                         i_space_flag,
    input  logic                         i_radix_prefix,
    input  logic                         i_fill_zeros,
    input  logic [5:0]                   i_field_width,
    input  logic                         i_has_precision,
    input  logic [5:0]                   i_digit_precision,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_out_char,
    output logic                         o_last,
    output logic                         o_empty_res
);
    import iff_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DABBLE = 11'b000_0000_0010,
        S_NORM   = 11'b000_0000_0100,
        S_PLAN   = 11'b000_0000_1000,
        S_SIZE   = 11'b000_0001_0000,
        S_PAD_L  = 11'b000_0010_0000,
        S_PREFIX = 11'b000_0100_0000,
        S_ZERO   = 11'b000_1000_0000,
        S_DIGIT  = 11'b001_0000_0000,
        S_PAD_R  = 11'b010_0000_0000,
        S_EMPTY  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Control counters.
    logic [STEP_W-1:0] r_step, n_step;
    logic [NDIG_W-1:0] r_ndig, n_ndig;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_lenm1, n_lenm1;

    // Captured request and the planned field layout.
    logic [2:0]        r_mode;
    logic [7:0]        r_char;
    logic              r_zero, r_neg, r_lj, r_plus, r_blank, r_alt, r_zpad, r_has_prec;
    logic [5:0]        r_width, r_prec;
    logic [1:0]        r_npre, n_npre;
    logic [7:0]        r_pre0, n_pre0, r_pre1, n_pre1;
    logic [CNT_W-1:0]  r_nzero, n_nzero;
    logic [NDIG_W-1:0] r_ndig_eff, n_ndig_eff;
    logic [CNT_W-1:0]  r_pad, n_pad;

    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last, r_out_empty;

    logic       accept, out_free, emit, emit_last, emit_empty;
    logic [7:0] emit_char;
    logic [5:0] prec_sat;
    t_du_ctrl   du_ctrl;
    logic [3:0] top_digit;

    logic [CNT_W-1:0] ndig_w, prec_w, width_w, npre_w, total, len;

    iff_digit_unit u_digits (
        .i_clk       (i_clk),
        .i_ctrl      (du_ctrl),
        .i_value     (i_value),
        .o_top_digit (top_digit)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign prec_sat = (i_digit_precision > 6'(PREC_MAX)) ? 6'(PREC_MAX) : i_digit_precision;

    assign ndig_w  = CNT_W'(r_ndig);
    assign prec_w  = CNT_W'(r_prec);
    assign width_w = CNT_W'(r_width);
    assign npre_w  = CNT_W'(r_npre);
    assign total   = npre_w + r_nzero + CNT_W'(r_ndig_eff);

    always_comb begin
        if (width_w > total) begin
            len = width_w;
        end else begin
            len = total;
        end
        if (len > CNT_W'(MAX_FIELD)) begin
            len = CNT_W'(MAX_FIELD);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_ndig     = r_ndig;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_lenm1    = r_lenm1;
        n_npre     = r_npre;
        n_pre0     = r_pre0;
        n_pre1     = r_pre1;
        n_nzero    = r_nzero;
        n_ndig_eff = r_ndig_eff;
        n_pad      = r_pad;
        du_ctrl.op     = DU_HOLD;
        du_ctrl.kind   = LD_DEC;
        du_ctrl.negate = (i_mode == MODE_SDEC) && i_value[VALUE_W-1];
        emit       = 1'b0;
        emit_char  = CH_SPACE;
        emit_empty = 1'b0;

        case (i_mode) inside
            MODE_LHEX, MODE_UHEX: du_ctrl.kind = LD_HEX;
            MODE_OCT:             du_ctrl.kind = LD_OCT;
            default:              du_ctrl.kind = LD_DEC;
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    du_ctrl.op = DU_LOAD;
                    n_ndig     = NDIG_W'(DIGIT_SLOTS);
                    n_step     = STEP_W'(VALUE_W - 1);
                    case (i_mode) inside
                        MODE_SDEC, MODE_UDEC:           n_state = S_DABBLE;
                        MODE_LHEX, MODE_UHEX, MODE_OCT: n_state = S_NORM;
                        default:                        n_state = S_PLAN;
                    endcase
                end
            end
            S_DABBLE: begin
                du_ctrl.op = DU_DABBLE;
                n_step     = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // Strip leading zero digits, keeping at least one.
                if (top_digit == 4'd0 && r_ndig > NDIG_W'(1)) begin
                    du_ctrl.op = DU_SHIFT;
                    n_ndig     = r_ndig - NDIG_W'(1);
                end else begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_npre     = 2'd0;
                n_pre0     = CH_ZERO;
                n_pre1     = CH_X_LO;
                n_nzero    = '0;
                n_ndig_eff = '0;
                if (r_mode == MODE_CHAR) begin
                    n_ndig_eff = NDIG_W'(1);
                end else if (r_mode <= MODE_OCT) begin
                    if (r_mode == MODE_SDEC) begin
                        if (r_neg) begin
                            n_npre = 2'd1;
                            n_pre0 = CH_MINUS;
                        end else if (r_plus) begin
                            n_npre = 2'd1;
                            n_pre0 = CH_PLUS;
                        end else if (r_blank) begin
                            n_npre = 2'd1;
                            n_pre0 = CH_SPACE;
                        end
                    end else if ((r_mode == MODE_LHEX || r_mode == MODE_UHEX)
                                 && r_alt && !r_zero) begin
                        n_npre = 2'd2;
                        n_pre1 = (r_mode == MODE_UHEX) ? CH_X_UP : CH_X_LO;
                    end else if (r_mode == MODE_OCT && r_alt && !r_zero
                                 && prec_w <= ndig_w) begin
                        // Octal gets its 0 only when precision zeros do not supply one.
                        n_npre = 2'd1;
                    end
                    if (prec_w > ndig_w) begin
                        n_nzero = prec_w - ndig_w;
                    end else if (r_zpad && !r_lj && !r_has_prec
                                 && width_w > CNT_W'(n_npre) + ndig_w) begin
                        n_nzero = width_w - (CNT_W'(n_npre) + ndig_w);
                    end
                    // A zero value with zero precision and no prefix has no digits.
                    if (r_zero && r_prec == 6'd0 && n_npre == 2'd0) begin
                        n_ndig_eff = '0;
                    end else begin
                        n_ndig_eff = r_ndig;
                    end
                end
                n_state = S_SIZE;
            end
            S_SIZE: begin
                n_pad   = (width_w > total) ? (width_w - total) : '0;
                n_lenm1 = len - CNT_W'(1);
                n_pos   = '0;
                n_cnt   = r_lj ? '0 : n_pad;
                n_state = (len == '0) ? S_EMPTY : S_PAD_L;
            end
            S_PAD_L: begin
                emit_char = CH_SPACE;
                if (r_cnt == '0) begin
                    n_cnt   = npre_w;
                    n_state = S_PREFIX;
                end else begin
                    emit = out_free;
                end
            end
            S_PREFIX: begin
                emit_char = (r_npre == 2'd2 && r_cnt == CNT_W'(1)) ? r_pre1 : r_pre0;
                if (r_cnt == '0) begin
                    n_cnt   = r_nzero;
                    n_state = S_ZERO;
                end else begin
                    emit = out_free;
                end
            end
            S_ZERO: begin
                emit_char = CH_ZERO;
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(r_ndig_eff);
                    n_state = S_DIGIT;
                end else begin
                    emit = out_free;
                end
            end
            S_DIGIT: begin
                emit_char = (r_mode == MODE_CHAR) ? r_char
                                                  : digit_char(top_digit, r_mode == MODE_UHEX);
                if (r_cnt == '0) begin
                    n_cnt   = r_lj ? r_pad : '0;
                    n_state = S_PAD_R;
                end else begin
                    emit = out_free;
                    if (out_free) begin
                        du_ctrl.op = DU_SHIFT;
                    end
                end
            end
            S_PAD_R: begin
                emit_char = CH_SPACE;
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    emit = out_free;
                end
            end
            S_EMPTY: begin
                emit_char  = CH_NUL;
                emit_empty = 1'b1;
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        emit_last = emit_empty || (r_pos == r_lenm1);
        if (emit && !emit_empty) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_pos = r_pos + CNT_W'(1);
            if (emit_last) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_ndig      <= '0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_lenm1     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ndig  <= n_ndig;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_lenm1 <= n_lenm1;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode     <= i_mode;
            r_char     <= i_value[7:0];
            r_zero     <= (i_value == '0);
            r_neg      <= (i_mode == MODE_SDEC) && i_value[VALUE_W-1];
            r_lj       <= i_pad_after;
            r_plus     <= i_plus_flag;
            r_blank    <= i_space_flag;
            r_alt      <= i_radix_prefix;
            r_zpad     <= i_fill_zeros;
            r_width    <= i_field_width;
            r_has_prec <= i_has_precision;
            r_prec     <= i_has_precision ? prec_sat : 6'd1;
        end
        r_npre     <= n_npre;
        r_pre0     <= n_pre0;
        r_pre1     <= n_pre1;
        r_nzero    <= n_nzero;
        r_ndig_eff <= n_ndig_eff;
        r_pad      <= n_pad;
        if (emit) begin
            r_out_char  <= emit_char;
            r_out_last  <= emit_last;
            r_out_empty <= emit_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_out_last;
    assign o_empty_res = r_out_empty;

    // An accepted request always leaves the idle state on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // An empty field is always a single, final word.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_res) |-> o_last)
        else $error("empty word without last mark");

    // Leading-zero stripping never removes the last digit.
    a_norm_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_ndig != '0))
        else $error("digit count reached zero while stripping");

    // The character position never passes the end of the field.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD_L || r_state == S_PREFIX || r_state == S_ZERO
         || r_state == S_DIGIT || r_state == S_PAD_R) |-> (r_pos <= r_lenm1))
        else $error("character position beyond field length");

endmodule
